[hw/rtl/sm4c_pkg.sv]
package sm4c_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned Rounds = 32;
  localparam int unsigned RndW   = $clog2(Rounds);

  // system parameter FK
  localparam word_t FK0 = 32'ha3b1bac6;
  localparam word_t FK1 = 32'h56aa3350;
  localparam word_t FK2 = 32'h677d9197;
  localparam word_t FK3 = 32'hb27022dc;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_HI = 2'd0;
  localparam logic [1:0] REG_KEY_LO = 2'd1;
  localparam logic [1:0] REG_IV_HI  = 2'd2;
  localparam logic [1:0] REG_IV_LO  = 2'd3;

  // write request into the round key store
  typedef struct packed {
    logic            en;
    logic [RndW-1:0] addr;
    word_t           data;
  } key_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // nonlinear byte substitution on a whole word
  function automatic word_t tau(input word_t v);
    word_t r;
    r = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    return r;
  endfunction

  // CK constant: byte j from the top is (4*i + j) * 7 mod 256
  function automatic word_t ck_word(input logic [RndW-1:0] i);
    word_t      w;
    logic [7:0] idx;
    for (int j = 0; j < 4; j++) begin
      idx = {1'b0, i, 2'(j)};
      w[31-8*j -: 8] = 8'(idx * 8'd7);
    end
    return w;
  endfunction

endpackage

[hw/rtl/sm4c_round.sv]
// One SM4 round, shared by key expansion (L') and encryption (L).
module sm4c_round (
  input  sm4c_pkg::word_t [3:0]           words,
  input  sm4c_pkg::word_t                 rkey,
  input  logic [sm4c_pkg::RndW-1:0]       rnd,
  input  logic                            key_mode,
  output sm4c_pkg::word_t                 new_word
);
  import sm4c_pkg::*;

  word_t t_in;
  word_t b;
  word_t lin;

  assign t_in = words[1] ^ words[2] ^ words[3] ^ (key_mode ? ck_word(rnd) : rkey);
  assign b    = tau(t_in);

  always_comb begin
    if (key_mode) begin
      lin = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    end else begin
      lin = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
              ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    end
  end

  assign new_word = words[0] ^ lin;

endmodule

[hw/rtl/sm4c_key_mem.sv]
// Round key store, one write port, registered read.
module sm4c_key_mem (
  input  logic                       clk,
  input  sm4c_pkg::key_wr_t          wr,
  input  logic [sm4c_pkg::RndW-1:0]  rd_addr,
  output sm4c_pkg::word_t            rd_data
);
  import sm4c_pkg::*;

  word_t mem [Rounds];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/sm4_cbc_encryptor.sv]
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata = plain_hi, plain_lo; tuser = first_block
// m_*      out  m_tvalid/m_tready  tdata = cipher_hi, cipher_lo
// cfg_*    in   cfg_valid/cfg_ready index 0..3 = key_hi, key_lo, iv_hi, iv_lo
//
// An item is accepted, runs 32 rounds in the shared round unit, then loads the
// output register. A first_block item first runs key expansion through the same
// round unit. s_tready is low while busy.
// rst is synchronous and clears the sequencer, output valid and chaining value.
// A result waiting on m_tready does not block the next item; only a second
// result finishing before the first is taken stalls in the last state.
module sm4_cbc_encryptor (
  input  logic         clk,
  input  logic         rst,
  // plaintext stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // [63:0] plain_hi, [127:64] plain_lo
  input  logic         s_tuser,   // [0] first_block
  // ciphertext stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // [63:0] cipher_hi, [127:64] cipher_lo
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import sm4c_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_KEY  = 4'b0010,
    S_ENC  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t          state;
  logic [RndW-1:0] cnt;
  word_t [3:0]     w;        // w[0] is the oldest word of the round window
  logic [127:0]    blk;      // whitened block parked during key expansion
  logic [127:0]    chain;    // {hi, lo}
  logic [63:0]     key_hi, key_lo, iv_hi, iv_lo;

  logic            in_fire;
  logic            out_free;
  logic [127:0]    pt;
  logic [127:0]    cipher;
  word_t           rk_q;
  word_t           nw;
  logic [RndW-1:0] rd_addr;
  key_wr_t         kw;

  assign in_fire   = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign pt        = {s_tdata[63:0], s_tdata[127:64]};
  // final word reversal
  assign cipher    = {w[3], w[2], w[1], w[0]};

  // config registers; key and IV are only sampled when a first block is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
      iv_hi  <= '0;
      iv_lo  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_HI: key_hi <= cfg_data;
        REG_KEY_LO: key_lo <= cfg_data;
        REG_IV_HI:  iv_hi  <= cfg_data;
        REG_IV_LO:  iv_lo  <= cfg_data;
        default:    ;
      endcase
    end
  end

  sm4c_round u_round (
    .words    (w),
    .rkey     (rk_q),
    .rnd      (cnt),
    .key_mode (state == S_KEY),
    .new_word (nw)
  );

  // during encryption rounds fetch the key for the next round; otherwise prefetch key 0
  assign rd_addr = (state == S_ENC) ? cnt + 1'b1 : '0;

  assign kw.en   = (state == S_KEY);
  assign kw.addr = cnt;
  assign kw.data = nw;

  sm4c_key_mem u_key_mem (
    .clk     (clk),
    .wr      (kw),
    .rd_addr (rd_addr),
    .rd_data (rk_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_fire) begin
            state <= s_tuser ? S_KEY : S_ENC;
          end
        end
        S_KEY: begin
          cnt <= cnt + 1'b1;
          if (cnt == RndW'(Rounds - 1)) begin
            state <= S_ENC;
          end
        end
        S_ENC: begin
          cnt <= cnt + 1'b1;
          if (cnt == RndW'(Rounds - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // round window and parked block
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (s_tuser) begin
            w   <= {key_lo[31:0] ^ FK3, key_lo[63:32] ^ FK2,
                    key_hi[31:0] ^ FK1, key_hi[63:32] ^ FK0};
            blk <= pt ^ {iv_hi, iv_lo};
          end else begin
            w   <= {pt[31:0] ^ chain[31:0], pt[63:32] ^ chain[63:32],
                    pt[95:64] ^ chain[95:64], pt[127:96] ^ chain[127:96]};
          end
        end
      end
      S_KEY: begin
        if (cnt == RndW'(Rounds - 1)) begin
          w <= {blk[31:0], blk[63:32], blk[95:64], blk[127:96]};
        end else begin
          w <= {nw, w[3], w[2], w[1]};
        end
      end
      S_ENC: begin
        w <= {nw, w[3], w[2], w[1]};
      end
      default: ;
    endcase
  end

  // output register and chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      chain    <= '0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
      chain    <= cipher;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {cipher[63:0], cipher[127:64]};
    end
  end

endmodule
